// ===== design/fxq88_pkg.sv =====
// ----------------------------------------------------------------------------
// fxq88_pkg
// Types and constants for the signed 8.8 multiply / divide / sqrt unit.
// ----------------------------------------------------------------------------
package fxq88_pkg;

  localparam logic [1:0] CMD_MUL  = 2'd0;
  localparam logic [1:0] CMD_DIV  = 2'd1;
  localparam logic [1:0] CMD_SQRT = 2'd2;

  localparam logic [15:0] SAT_POS   = 16'd32767;
  localparam logic [15:0] DIV_LIMIT = 16'd126;
  localparam logic [14:0] ROOT_BIT0 = 15'h4000;

  localparam int DIV_STEPS  = 24;
  localparam int ROOT_STEPS = 8;

  typedef enum logic [2:0] {
    S_IDLE,
    S_MUL,
    S_ROOT,
    S_DIV,
    S_DSAT,
    S_SIGN,
    S_AVG,
    S_FIN
  } state_t;

endpackage

// ===== design/fixed_point_q8_8_mul_div_sqrt.sv =====
// ----------------------------------------------------------------------------
// fixed_point_q8_8_mul_div_sqrt
// Signed 8.8 arithmetic unit: multiply, divide and square root, one result
// per transaction.
// ----------------------------------------------------------------------------
// One transaction is taken at a time; cmd_ready is high only while the unit is
// idle. A multiply runs one 17x17 product, a sign step and the output load
// before result_valid. A divide runs a restoring division on one shared 17-bit
// subtractor, one quotient bit per cycle; a zero divisor, a non-positive square
// root operand or the unused command code go straight to the output load. A
// square root runs 8 bit-method root steps and then a 24-step division on the
// same subtractor. The result sits in an output register, so a new transaction
// may start while the previous result still waits to be taken.
// ----------------------------------------------------------------------------
module fixed_point_q8_8_mul_div_sqrt
  import fxq88_pkg::*;
(
  input  logic               clk,
  input  logic               rst,
  input  logic               cmd_valid,
  output logic               cmd_ready,
  input  logic [1:0]         cmd,
  input  logic signed [15:0] operand_a,
  input  logic signed [15:0] operand_b,
  output logic               result_valid,
  input  logic               result_ready,
  output logic signed [15:0] result
);

  state_t state;
  state_t state_next;

  logic [16:0] ma;
  logic [16:0] mb;
  logic        neg;
  logic        is_sqrt;
  logic [15:0] rem;
  logic [23:0] dvd;
  logic [15:0] root;
  logic [14:0] bitm;
  logic [4:0]  cnt;
  logic [15:0] mag;
  logic [15:0] res;

  logic [16:0] in_ma;
  logic [16:0] in_mb;
  logic        accept;
  logic        out_free;
  logic        load_out;

  logic [16:0] sub_x;
  logic [16:0] sub_y;
  logic [17:0] diff;
  logic        borrow;
  logic [15:0] root_t;
  logic [15:0] root_next;
  logic [33:0] product;
  logic [16:0] avg_sum;

  // operand magnitudes, -32768 maps to 32768
  assign in_ma = operand_a[15] ? (17'h10000 - {1'b0, operand_a}) : {1'b0, operand_a};
  assign in_mb = operand_b[15] ? (17'h10000 - {1'b0, operand_b}) : {1'b0, operand_b};

  assign accept   = cmd_valid && cmd_ready;
  assign out_free = !result_valid || result_ready;

  // shared subtractor
  assign root_t = root + {1'b0, bitm};
  always_comb begin
    if (state == S_ROOT) begin
      sub_x = {1'b0, rem};
      sub_y = {1'b0, root_t};
    end else begin
      sub_x = {rem, dvd[23]};
      sub_y = mb;
    end
  end
  assign diff      = {1'b0, sub_x} - {1'b0, sub_y};
  assign borrow    = diff[17];
  assign root_next = borrow ? (root >> 1) : ((root >> 1) + {1'b0, bitm});

  assign product = ma * mb;
  assign avg_sum = {1'b0, mb[15:0]} + {1'b0, mag};

  // next state
  always_comb begin
    state_next = state;
    unique case (state)
      S_IDLE: begin
        if (cmd_valid) begin
          unique case (cmd)
            CMD_MUL:  state_next = S_MUL;
            CMD_DIV:  state_next = (operand_b == 16'sd0) ? S_FIN : S_DIV;
            CMD_SQRT: state_next = (operand_a[15] || operand_a == 16'sd0) ? S_FIN : S_ROOT;
            default:  state_next = S_FIN;
          endcase
        end
      end
      S_MUL:  state_next = S_SIGN;
      S_ROOT: state_next = (cnt == 5'(ROOT_STEPS - 1)) ? S_DIV : S_ROOT;
      S_DIV:  state_next = (cnt == 5'(DIV_STEPS - 1)) ? S_DSAT : S_DIV;
      S_DSAT: state_next = is_sqrt ? S_AVG : S_SIGN;
      S_SIGN: state_next = S_FIN;
      S_AVG:  state_next = S_FIN;
      S_FIN:  state_next = out_free ? S_IDLE : S_FIN;
      default: state_next = S_IDLE;
    endcase
  end

  // handshake outputs
  always_comb begin
    cmd_ready = (state == S_IDLE);
    load_out  = (state == S_FIN) && out_free;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state        <= S_IDLE;
      result_valid <= 1'b0;
    end else begin
      state <= state_next;
      if (load_out) begin
        result_valid <= 1'b1;
      end else if (result_ready) begin
        result_valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (load_out) begin
      result <= res;
    end
    unique case (state)
      S_IDLE: begin
        if (accept) begin
          ma      <= in_ma;
          mb      <= in_mb;
          is_sqrt <= (cmd == CMD_SQRT);
          dvd     <= {in_ma[15:0], 8'd0};
          cnt     <= 5'd0;
          root    <= 16'd0;
          bitm    <= ROOT_BIT0;
          // remainder starts from magnitude bit 16; 32768 sets the top dividend bit
          unique case (cmd)
            CMD_DIV: begin
              neg <= operand_a[15] ^ operand_b[15];
              rem <= {15'd0, in_ma[16]};
              res <= SAT_POS;
            end
            CMD_SQRT: begin
              neg <= 1'b0;
              rem <= operand_a;
              res <= 16'd0;
            end
            default: begin
              neg <= operand_a[15] ^ operand_b[15];
              rem <= {15'd0, in_ma[16]};
              res <= 16'd0;
            end
          endcase
        end
      end
      S_MUL: begin
        mag <= product[23:8];
      end
      S_ROOT: begin
        root <= root_next;
        bitm <= bitm >> 2;
        if (cnt == 5'(ROOT_STEPS - 1)) begin
          // seed y = root * 16, then divide a by y
          mb  <= {1'b0, root_next[11:0], 4'd0};
          rem <= 16'd0;
          dvd <= {ma[15:0], 8'd0};
          cnt <= 5'd0;
        end else begin
          if (!borrow) begin
            rem <= diff[15:0];
          end
          cnt <= cnt + 5'd1;
        end
      end
      S_DIV: begin
        rem <= borrow ? sub_x[15:0] : diff[15:0];
        dvd <= {dvd[22:0], !borrow};
        cnt <= cnt + 5'd1;
      end
      S_DSAT: begin
        mag <= (dvd[23:8] > DIV_LIMIT) ? SAT_POS : dvd[15:0];
      end
      S_SIGN: begin
        res <= neg ? (16'd0 - mag) : mag;
      end
      S_AVG: begin
        res <= avg_sum[16:1];
      end
      S_FIN: begin
      end
      default: begin
      end
    endcase
  end

endmodule
